// File: rtl/ttqg_pkg.sv
// Package for the tiling quad generator: payload types, codes and the control store.
package ttqg_pkg;

    localparam int FIELD_BITS     = 16;
    localparam int DEF_MAX_QUADS  = 64;
    localparam int DEF_COORD_BITS = 16;

    localparam logic [1:0] WRAP_CLAMP  = 2'd0;
    localparam logic [1:0] WRAP_REPEAT = 2'd1;

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ZSRC  = 2'd2;

    localparam logic [0:0] REG_TILE_MODE = 1'd0;

    typedef struct packed {
        logic [FIELD_BITS-1:0] dst_x;
        logic [FIELD_BITS-1:0] dst_y;
        logic [FIELD_BITS-1:0] dst_w;
        logic [FIELD_BITS-1:0] dst_h;
        logic [FIELD_BITS-1:0] src_x;
        logic [FIELD_BITS-1:0] src_y;
        logic [FIELD_BITS-1:0] src_w;
        logic [FIELD_BITS-1:0] src_h;
    } t_request;

    typedef struct packed {
        logic [FIELD_BITS-1:0] quad_x;
        logic [FIELD_BITS-1:0] quad_y;
        logic [FIELD_BITS-1:0] tex_x;
        logic [FIELD_BITS-1:0] tex_y;
        logic [FIELD_BITS-1:0] quad_w;
        logic [FIELD_BITS-1:0] quad_h;
        logic [1:0]            status;
        logic                  truncated;
        logic                  last;
    } t_result;

    // Datapath operations.
    localparam logic [4:0] OP_NOP      = 5'd0;
    localparam logic [4:0] OP_DIVW_INIT = 5'd1;
    localparam logic [4:0] OP_DIV_STEP = 5'd2;
    localparam logic [4:0] OP_SAVE_W   = 5'd3;
    localparam logic [4:0] OP_SAVE_H   = 5'd4;
    localparam logic [4:0] OP_MUL_NN   = 5'd5;
    localparam logic [4:0] OP_TOTAL    = 5'd6;
    localparam logic [4:0] OP_XEND     = 5'd7;
    localparam logic [4:0] OP_YEND     = 5'd8;
    localparam logic [4:0] OP_EMIT_A   = 5'd9;
    localparam logic [4:0] OP_INIT_B   = 5'd10;
    localparam logic [4:0] OP_EMIT_B   = 5'd11;
    localparam logic [4:0] OP_INIT_C   = 5'd12;
    localparam logic [4:0] OP_EMIT_C   = 5'd13;
    localparam logic [4:0] OP_EMIT_D   = 5'd14;
    localparam logic [4:0] OP_CLAMP    = 5'd15;
    localparam logic [4:0] OP_EMPTY    = 5'd16;
    localparam logic [4:0] OP_ZSRC     = 5'd17;

    // Jump conditions.
    localparam logic [3:0] C_NEVER    = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NOSTART  = 4'd2;
    localparam logic [3:0] C_CLAMP    = 4'd3;
    localparam logic [3:0] C_NOTREP   = 4'd4;
    localparam logic [3:0] C_SRCZ     = 4'd5;
    localparam logic [3:0] C_DIV_BUSY = 4'd6;
    localparam logic [3:0] C_NQZERO   = 4'd7;
    localparam logic [3:0] C_A_EMPTY  = 4'd8;
    localparam logic [3:0] C_A_MORE   = 4'd9;
    localparam logic [3:0] C_B_EMPTY  = 4'd10;
    localparam logic [3:0] C_B_MORE   = 4'd11;
    localparam logic [3:0] C_C_EMPTY  = 4'd12;
    localparam logic [3:0] C_C_MORE   = 4'd13;

    // Program steps.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP0 = 5'd1;
    localparam logic [4:0] S_DISP1 = 5'd2;
    localparam logic [4:0] S_DISP2 = 5'd3;
    localparam logic [4:0] S_DIVW  = 5'd4;
    localparam logic [4:0] S_SAVEW = 5'd5;
    localparam logic [4:0] S_DIVH  = 5'd6;
    localparam logic [4:0] S_SAVEH = 5'd7;
    localparam logic [4:0] S_MULNN = 5'd8;
    localparam logic [4:0] S_TOTAL = 5'd9;
    localparam logic [4:0] S_XEND  = 5'd10;
    localparam logic [4:0] S_YEND  = 5'd11;
    localparam logic [4:0] S_CHKA  = 5'd12;
    localparam logic [4:0] S_EMITA = 5'd13;
    localparam logic [4:0] S_INITB = 5'd14;
    localparam logic [4:0] S_EMITB = 5'd15;
    localparam logic [4:0] S_INITC = 5'd16;
    localparam logic [4:0] S_EMITC = 5'd17;
    localparam logic [4:0] S_EMITD = 5'd18;
    localparam logic [4:0] S_CLAMP = 5'd19;
    localparam logic [4:0] S_EMPTY = 5'd20;
    localparam logic [4:0] S_ZSRC  = 5'd21;

    typedef struct packed {
        logic [4:0] op;
        logic [3:0] cnd;
        logic [4:0] tgt;
        logic       fin;  // an emit that delivers the final beat ends the program
    } t_uword;

    function automatic t_uword uc_rom(input logic [4:0] pc);
        t_uword uw;
        unique case (pc)
            S_IDLE:  uw = '{op: OP_NOP,       cnd: C_NOSTART,  tgt: S_IDLE,  fin: 1'b0};
            S_DISP0: uw = '{op: OP_NOP,       cnd: C_CLAMP,    tgt: S_CLAMP, fin: 1'b0};
            S_DISP1: uw = '{op: OP_NOP,       cnd: C_NOTREP,   tgt: S_EMPTY, fin: 1'b0};
            S_DISP2: uw = '{op: OP_DIVW_INIT, cnd: C_SRCZ,     tgt: S_ZSRC,  fin: 1'b0};
            S_DIVW:  uw = '{op: OP_DIV_STEP,  cnd: C_DIV_BUSY, tgt: S_DIVW,  fin: 1'b0};
            S_SAVEW: uw = '{op: OP_SAVE_W,    cnd: C_NEVER,    tgt: S_IDLE,  fin: 1'b0};
            S_DIVH:  uw = '{op: OP_DIV_STEP,  cnd: C_DIV_BUSY, tgt: S_DIVH,  fin: 1'b0};
            S_SAVEH: uw = '{op: OP_SAVE_H,    cnd: C_NEVER,    tgt: S_IDLE,  fin: 1'b0};
            S_MULNN: uw = '{op: OP_MUL_NN,    cnd: C_NEVER,    tgt: S_IDLE,  fin: 1'b0};
            S_TOTAL: uw = '{op: OP_TOTAL,     cnd: C_NEVER,    tgt: S_IDLE,  fin: 1'b0};
            S_XEND:  uw = '{op: OP_XEND,      cnd: C_NEVER,    tgt: S_IDLE,  fin: 1'b0};
            S_YEND:  uw = '{op: OP_YEND,      cnd: C_NQZERO,   tgt: S_EMPTY, fin: 1'b0};
            S_CHKA:  uw = '{op: OP_NOP,       cnd: C_A_EMPTY,  tgt: S_INITB, fin: 1'b0};
            S_EMITA: uw = '{op: OP_EMIT_A,    cnd: C_A_MORE,   tgt: S_EMITA, fin: 1'b1};
            S_INITB: uw = '{op: OP_INIT_B,    cnd: C_B_EMPTY,  tgt: S_INITC, fin: 1'b0};
            S_EMITB: uw = '{op: OP_EMIT_B,    cnd: C_B_MORE,   tgt: S_EMITB, fin: 1'b1};
            S_INITC: uw = '{op: OP_INIT_C,    cnd: C_C_EMPTY,  tgt: S_EMITD, fin: 1'b0};
            S_EMITC: uw = '{op: OP_EMIT_C,    cnd: C_C_MORE,   tgt: S_EMITC, fin: 1'b1};
            S_EMITD: uw = '{op: OP_EMIT_D,    cnd: C_ALWAYS,   tgt: S_IDLE,  fin: 1'b1};
            S_CLAMP: uw = '{op: OP_CLAMP,     cnd: C_ALWAYS,   tgt: S_IDLE,  fin: 1'b0};
            S_EMPTY: uw = '{op: OP_EMPTY,     cnd: C_ALWAYS,   tgt: S_IDLE,  fin: 1'b0};
            S_ZSRC:  uw = '{op: OP_ZSRC,      cnd: C_ALWAYS,   tgt: S_IDLE,  fin: 1'b0};
            default: uw = '{op: OP_NOP,       cnd: C_ALWAYS,   tgt: S_IDLE,  fin: 1'b0};
        endcase
        return uw;
    endfunction

endpackage

// File: rtl/texture_tiling_quad_generator_unit.sv
// Tiling quad generator top level: microcoded sequencer, shared divider and multiplier.
//
//   channel   handshake              payload        direction
//   request   start / busy           i_req          in
//   result    o_strobe               o_result       out
//   config    psel/penable/pwrite    paddr, pwdata  in  (prdata, pready out)
//
// Repeat mode holds busy while it runs: two divisions and the control steps come first,
// then one quad leaves per cycle, N quads in all (N up to MAX_QUADS), but a set-up step
// may pass before the right column and another before the bottom row. A repeat request
// with nothing to draw, clamp, any other tile mode and a zero source size end sooner.
// Each beat shows on o_result in the cycle after the step that makes it.
// Reset is synchronous and active low; it clears the sequencer, the strobe and sets
// the tile mode to repeat. The receiver cannot stall: each beat is on o_result for one cycle.
module texture_tiling_quad_generator_unit
    import ttqg_pkg::*;
#(
    parameter int MAX_QUADS  = DEF_MAX_QUADS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_request    i_req,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_BITS = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int CNT_BITS = $clog2(MAX_QUADS + 1);
    localparam int TOT_BITS = 2 * FIELD_BITS + 1;
    localparam int DCNT_BITS = $clog2(FIELD_BITS + 1);

    // Control registers.
    logic [4:0]          r_pc, n_pc;
    logic                r_strobe, n_strobe;
    logic [1:0]          r_wrap;

    // Datapath registers.
    t_request              r_req;
    t_result               r_out, n_out;
    logic [FIELD_BITS-1:0] r_rem, r_quo, r_dvs;
    logic [DCNT_BITS-1:0]  r_dcnt;
    logic [FIELD_BITS-1:0] r_nh, r_nv, r_ph, r_pv;
    logic [2*FIELD_BITS-1:0] r_prod;
    logic [CNT_BITS-1:0]   r_nq, r_cnt;
    logic                  r_trunc;
    logic [POS_BITS-1:0]   r_px, r_py, r_xe, r_ye;
    logic [FIELD_BITS-1:0] r_ci, r_rk;

    t_uword                uw;
    logic                  accept;
    logic                  cfg_wr;
    logic                  cond;
    logic                  emit_last;
    logic                  a_row_end;
    logic                  ph_nz, pv_nz;
    logic [FIELD_BITS:0]   div_t;
    logic                  div_ge;
    logic [FIELD_BITS-1:0] mul_a, mul_b;
    logic [2*FIELD_BITS-1:0] mul_p;
    logic [TOT_BITS-1:0]   tot_sum;
    logic                  tot_over;
    logic [POS_BITS-1:0]   sw_p, sh_p;

    assign uw     = uc_rom(r_pc);
    assign accept = start && (r_pc == S_IDLE);
    assign busy   = (r_pc != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TILE_MODE) ? 32'(r_wrap) : 32'd0;

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    assign ph_nz     = (r_ph != '0);
    assign pv_nz     = (r_pv != '0);
    assign a_row_end = (r_ci == r_nh - 1'b1);
    assign emit_last = (CNT_BITS'(r_cnt + 1'b1) == r_nq);
    assign sw_p      = r_req.src_w[POS_BITS-1:0];
    assign sh_p      = r_req.src_h[POS_BITS-1:0];

    // One restoring division step.
    assign div_t  = {r_rem, r_quo[FIELD_BITS-1]};
    assign div_ge = (div_t >= {1'b0, r_dvs});

    // The multiplier is shared by the tile count and the right and bottom edge offsets.
    always_comb begin
        mul_a = r_nh;
        mul_b = r_nv;
        case (uw.op)
            OP_TOTAL: begin
                mul_a = r_nh;
                mul_b = r_req.src_w;
            end
            OP_XEND: begin
                mul_a = r_nv;
                mul_b = r_req.src_h;
            end
            default: begin
                mul_a = r_nh;
                mul_b = r_nv;
            end
        endcase
    end

    assign mul_p = (2*FIELD_BITS)'(mul_a) * (2*FIELD_BITS)'(mul_b);

    assign tot_sum = {1'b0, r_prod}
                   + TOT_BITS'(ph_nz ? r_nv : '0)
                   + TOT_BITS'(pv_nz ? r_nh : '0)
                   + TOT_BITS'(ph_nz && pv_nz);
    assign tot_over = (tot_sum > TOT_BITS'(MAX_QUADS));

    always_comb begin
        cond = 1'b0;
        unique case (uw.cnd)
            C_NEVER:    cond = 1'b0;
            C_ALWAYS:   cond = 1'b1;
            C_NOSTART:  cond = !start;
            C_CLAMP:    cond = (r_wrap == WRAP_CLAMP);
            C_NOTREP:   cond = (r_wrap != WRAP_REPEAT);
            C_SRCZ:     cond = (r_req.src_w == '0) || (r_req.src_h == '0);
            C_DIV_BUSY: cond = (r_dcnt != DCNT_BITS'(1));
            C_NQZERO:   cond = (r_nq == '0);
            C_A_EMPTY:  cond = (r_nh == '0) || (r_nv == '0);
            C_A_MORE:   cond = !(a_row_end && (r_rk == r_nv - 1'b1));
            C_B_EMPTY:  cond = !ph_nz || (r_nv == '0);
            C_B_MORE:   cond = (r_rk != r_nv - 1'b1);
            C_C_EMPTY:  cond = !pv_nz || (r_nh == '0);
            C_C_MORE:   cond = (r_ci != r_nh - 1'b1);
            default:    cond = 1'b0;
        endcase
    end

    always_comb begin
        if (uw.fin && emit_last) begin
            n_pc = S_IDLE;
        end else if (cond) begin
            n_pc = uw.tgt;
        end else begin
            n_pc = r_pc + 5'd1;
        end
    end

    // Result beat for this step.
    always_comb begin
        n_strobe         = 1'b1;
        n_out.quad_x     = FIELD_BITS'(r_px);
        n_out.quad_y     = FIELD_BITS'(r_py);
        n_out.tex_x      = r_req.src_x;
        n_out.tex_y      = r_req.src_y;
        n_out.quad_w     = r_req.src_w;
        n_out.quad_h     = r_req.src_h;
        n_out.status     = ST_VALID;
        n_out.truncated  = emit_last && r_trunc;
        n_out.last       = emit_last;
        unique case (uw.op)
            OP_EMIT_A: begin
            end
            OP_EMIT_B: begin
                n_out.quad_x = FIELD_BITS'(r_xe);
                n_out.quad_w = r_ph;
            end
            OP_EMIT_C: begin
                n_out.quad_y = FIELD_BITS'(r_ye);
                n_out.quad_h = r_pv;
            end
            OP_EMIT_D: begin
                n_out.quad_x = FIELD_BITS'(r_xe);
                n_out.quad_y = FIELD_BITS'(r_ye);
                n_out.quad_w = r_ph;
                n_out.quad_h = r_pv;
            end
            OP_CLAMP: begin
                n_out.quad_x    = FIELD_BITS'(r_req.dst_x[POS_BITS-1:0]);
                n_out.quad_y    = FIELD_BITS'(r_req.dst_y[POS_BITS-1:0]);
                n_out.quad_w    = (r_req.dst_w < r_req.src_w) ? r_req.dst_w : r_req.src_w;
                n_out.quad_h    = (r_req.dst_h < r_req.src_h) ? r_req.dst_h : r_req.src_h;
                n_out.truncated = 1'b0;
                n_out.last      = 1'b1;
            end
            OP_EMPTY, OP_ZSRC: begin
                n_out        = '0;
                n_out.status = (uw.op == OP_ZSRC) ? ST_ZSRC : ST_EMPTY;
                n_out.last   = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= S_IDLE;
            r_strobe <= 1'b0;
            r_wrap   <= WRAP_REPEAT;
        end else begin
            r_pc     <= n_pc;
            r_strobe <= n_strobe;
            if (cfg_wr && (paddr[2] == REG_TILE_MODE)) begin
                r_wrap <= pwdata[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_req <= i_req;
            r_cnt <= '0;
        end
        unique case (uw.op)
            OP_DIVW_INIT: begin
                r_rem  <= '0;
                r_quo  <= r_req.dst_w;
                r_dvs  <= r_req.src_w;
                r_dcnt <= DCNT_BITS'(FIELD_BITS);
            end
            OP_DIV_STEP: begin
                r_rem  <= div_ge ? FIELD_BITS'(div_t - {1'b0, r_dvs}) : div_t[FIELD_BITS-1:0];
                r_quo  <= {r_quo[FIELD_BITS-2:0], div_ge};
                r_dcnt <= r_dcnt - 1'b1;
            end
            OP_SAVE_W: begin
                r_nh   <= r_quo;
                r_ph   <= r_rem;
                r_rem  <= '0;
                r_quo  <= r_req.dst_h;
                r_dvs  <= r_req.src_h;
                r_dcnt <= DCNT_BITS'(FIELD_BITS);
            end
            OP_SAVE_H: begin
                r_nv <= r_quo;
                r_pv <= r_rem;
            end
            OP_MUL_NN: begin
                r_prod <= mul_p;
            end
            OP_TOTAL: begin
                r_nq    <= tot_over ? CNT_BITS'(MAX_QUADS) : tot_sum[CNT_BITS-1:0];
                r_trunc <= tot_over;
                r_prod  <= mul_p;
            end
            OP_XEND: begin
                r_xe   <= r_req.dst_x[POS_BITS-1:0] + r_prod[POS_BITS-1:0];
                r_prod <= mul_p;
            end
            OP_YEND: begin
                r_ye <= r_req.dst_y[POS_BITS-1:0] + r_prod[POS_BITS-1:0];
                r_px <= r_req.dst_x[POS_BITS-1:0];
                r_py <= r_req.dst_y[POS_BITS-1:0];
                r_ci <= '0;
                r_rk <= '0;
            end
            OP_EMIT_A: begin
                r_cnt <= r_cnt + 1'b1;
                if (a_row_end) begin
                    r_ci <= '0;
                    r_px <= r_req.dst_x[POS_BITS-1:0];
                    r_rk <= r_rk + 1'b1;
                    r_py <= r_py + sh_p;
                end else begin
                    r_ci <= r_ci + 1'b1;
                    r_px <= r_px + sw_p;
                end
            end
            OP_INIT_B: begin
                r_py <= r_req.dst_y[POS_BITS-1:0];
                r_rk <= '0;
            end
            OP_EMIT_B: begin
                r_cnt <= r_cnt + 1'b1;
                r_rk  <= r_rk + 1'b1;
                r_py  <= r_py + sh_p;
            end
            OP_INIT_C: begin
                r_px <= r_req.dst_x[POS_BITS-1:0];
                r_ci <= '0;
            end
            OP_EMIT_C: begin
                r_cnt <= r_cnt + 1'b1;
                r_ci  <= r_ci + 1'b1;
                r_px  <= r_px + sw_p;
            end
            OP_EMIT_D: begin
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    // Every emit step still has at least one quad left to deliver.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_EMITA || r_pc == S_EMITB || r_pc == S_EMITC || r_pc == S_EMITD)
        |-> (r_cnt < r_nq))
        else $error("quad count ran past its limit");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe)
        else $error("beat right after the final beat of a request");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_VALID || o_result.truncated))
        |-> o_result.last)
        else $error("status or truncation beat is not the final beat");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("sequencer did not start on an accepted request");
`endif

endmodule
